/* rtl/lbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbt_pkg
// Shared types, widths, codes and the saturation helper for the Lorentz
// boost transform.
// ----------------------------------------------------------------------------
package lbt_pkg;

    localparam int WORD_W = 32;
    localparam int PROD_W = 64;
    localparam int SUM_W  = 66;
    localparam int WIDE_W = 67;
    localparam int ADDR_W = 4;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [3:0][WORD_W-1:0] t_row;
    typedef logic [3:0][3:0][WORD_W-1:0] t_mat;
    typedef logic [3:0][SUM_W-1:0] t_sums;

    typedef enum logic [1:0] {
        REG_GAMMA,
        REG_UX,
        REG_UY,
        REG_UZ
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_MUL,
        ST_DIV0,
        ST_DIV,
        ST_GM,
        ST_WR
    } t_bld_state;

    typedef struct packed {
        logic ld_prod;
        logic ld_sum;
    } t_lane_ctl;

    // Clamp a wide signed value to the 32-bit word range
    function automatic t_word sat_word(input logic signed [WIDE_W-1:0] x);
        t_word res;
        if ((&x[WIDE_W-1:WORD_W-1]) || !(|x[WIDE_W-1:WORD_W-1])) begin
            res = x[WORD_W-1:0];
        end else if (x[WIDE_W-1]) begin
            res = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

/* rtl/lbt_vec_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbt_vec_if
// Input channel: one four-vector word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lbt_vec_if;
    logic          valid;
    logic          ready;
    lbt_pkg::t_word vec_t;
    lbt_pkg::t_word vec_x;
    lbt_pkg::t_word vec_y;
    lbt_pkg::t_word vec_z;

    modport source (output valid, output vec_t, output vec_x, output vec_y,
                    output vec_z, input ready);
    modport sink   (input valid, input vec_t, input vec_x, input vec_y,
                    input vec_z, output ready);
endinterface

/* rtl/lbt_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbt_res_if
// Output channel: one boosted four-vector word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lbt_res_if;
    logic          valid;
    logic          ready;
    lbt_pkg::t_word out_t;
    lbt_pkg::t_word out_x;
    lbt_pkg::t_word out_y;
    lbt_pkg::t_word out_z;

    modport source (output valid, output out_t, output out_x, output out_y,
                    output out_z, input ready);
    modport sink   (input valid, input out_t, input out_x, input out_y,
                    input out_z, output ready);
endinterface

/* rtl/lbt_builder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbt_builder
// Configuration registers and a sequencer that rebuilds the boost matrix
// after every register write: squared norm, per-pair product, bit-serial
// normalizing division, scale by gamma-1, round and saturate.
// ----------------------------------------------------------------------------
module lbt_builder #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [lbt_pkg::ADDR_W-1:0]  i_addr,
    input  lbt_pkg::t_word              i_wr_data,
    output lbt_pkg::t_word              o_rd_data,
    output lbt_pkg::t_mat               o_matrix,
    output logic                        o_busy
);
    import lbt_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic signed [WORD_W:0] ONE_GM = (WORD_W + 1)'(1) << FRAC_BITS;
    localparam t_word ONE_Q = WORD_W'(1) << FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] HALF_W = WIDE_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [WIDE_W-1:0] ONE_W2 = WIDE_W'(1) << (2 * FRAC_BITS);

    t_word r_gamma, r_ux, r_uy, r_uz;
    t_bld_state r_state, n_state;
    logic [1:0]              r_sq_idx;
    logic [2:0]              r_pair;
    logic [CNT_W-1:0]        r_cnt;
    logic [PROD_W-1:0]       r_s;
    logic signed [PROD_W-1:0] r_p;
    logic [PROD_W-1:0]       r_rem;
    logic [WORD_W-1:0]       r_q;
    logic                    r_neg;
    logic signed [PROD_W:0]  r_prod;
    t_word                   r_ent [6];

    t_reg_idx                 wr_idx;
    t_word                    sq_u, a_u, b_u;
    logic [1:0]               pi, pj;
    logic signed [PROD_W-1:0] sq, pij;
    logic [PROD_W-1:0]        m_abs;
    logic [PROD_W:0]          rem2;
    logic                     ge, rnd, diag;
    logic [WORD_W-1:0]        q_fin;
    logic signed [WORD_W-1:0] r_sgn;
    logic signed [WORD_W:0]   gm1;
    logic signed [PROD_W:0]   gm_prod;
    logic signed [WIDE_W-1:0] term, term_sh;
    t_word                    ent_val;

    function automatic t_word u_of(input logic [1:0] k, input t_word ux,
                                   input t_word uy, input t_word uz);
        t_word v;
        unique case (k)
            2'd0:    v = ux;
            2'd1:    v = uy;
            default: v = uz;
        endcase
        return v;
    endfunction

    function automatic t_word neg_sat(input t_word v);
        t_word res;
        if (v == {1'b1, {(WORD_W-1){1'b0}}}) begin
            res = {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            res = -v;
        end
        return res;
    endfunction

    // Map pair index to spatial row and column (upper triangle)
    always_comb begin
        unique case (r_pair)
            3'd0:    begin pi = 2'd0; pj = 2'd0; end
            3'd1:    begin pi = 2'd0; pj = 2'd1; end
            3'd2:    begin pi = 2'd0; pj = 2'd2; end
            3'd3:    begin pi = 2'd1; pj = 2'd1; end
            3'd4:    begin pi = 2'd1; pj = 2'd2; end
            default: begin pi = 2'd2; pj = 2'd2; end
        endcase
    end

    // Datapath for the build steps
    always_comb begin
        wr_idx  = t_reg_idx'(i_addr[3:2]);
        sq_u    = u_of(r_sq_idx, r_ux, r_uy, r_uz);
        a_u     = u_of(pi, r_ux, r_uy, r_uz);
        b_u     = u_of(pj, r_ux, r_uy, r_uz);
        sq      = sq_u * sq_u;
        pij     = a_u * b_u;
        m_abs   = r_p[PROD_W-1] ? PROD_W'(-r_p) : PROD_W'(r_p);
        rem2    = {r_rem, 1'b0};
        ge      = rem2 >= {1'b0, r_s};
        rnd     = (r_rem != '0) && ge;
        q_fin   = (r_s == '0) ? '0 : r_q + WORD_W'(rnd);
        r_sgn   = r_neg ? -$signed(q_fin) : $signed(q_fin);
        gm1     = $signed({r_gamma[WORD_W-1], r_gamma}) - ONE_GM;
        gm_prod = gm1 * r_sgn;
        diag    = (pi == pj);
        term    = WIDE_W'(r_prod) + HALF_W + (diag ? ONE_W2 : '0);
        term_sh = term >>> FRAC_BITS;
        ent_val = sat_word(term_sh);
    end

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through the build steps; a write restarts the build
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: n_state = ST_IDLE;
            ST_SQ:   n_state = (r_sq_idx == 2'd2) ? ST_MUL : ST_SQ;
            ST_MUL:  n_state = ST_DIV0;
            ST_DIV0: n_state = ST_DIV;
            ST_DIV:  n_state = (r_cnt == CNT_W'(FRAC_BITS - 1)) ? ST_GM : ST_DIV;
            ST_GM:   n_state = ST_WR;
            ST_WR:   n_state = (r_pair == 3'd5) ? ST_IDLE : ST_MUL;
            default: n_state = ST_IDLE;
        endcase
        if (i_wr_en) begin
            n_state = ST_SQ;
        end
    end

    // Registers and build datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma  <= ONE_Q;
            r_ux     <= '0;
            r_uy     <= '0;
            r_uz     <= '0;
            r_sq_idx <= '0;
            r_pair   <= '0;
            r_cnt    <= '0;
            r_ent[0] <= ONE_Q;
            r_ent[1] <= '0;
            r_ent[2] <= '0;
            r_ent[3] <= ONE_Q;
            r_ent[4] <= '0;
            r_ent[5] <= ONE_Q;
        end else if (i_wr_en) begin
            unique case (wr_idx)
                REG_GAMMA: r_gamma <= i_wr_data;
                REG_UX:    r_ux    <= i_wr_data;
                REG_UY:    r_uy    <= i_wr_data;
                default:   r_uz    <= i_wr_data;
            endcase
            r_s      <= '0;
            r_sq_idx <= '0;
            r_pair   <= '0;
        end else begin
            unique case (r_state)
                ST_SQ: begin
                    r_s      <= r_s + PROD_W'(sq);
                    r_sq_idx <= r_sq_idx + 2'd1;
                end
                ST_MUL: begin
                    r_p <= pij;
                end
                ST_DIV0: begin
                    r_neg <= r_p[PROD_W-1];
                    r_cnt <= '0;
                    if (m_abs >= r_s) begin
                        r_q   <= WORD_W'(1);
                        r_rem <= '0;
                    end else begin
                        r_q   <= '0;
                        r_rem <= m_abs;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (ge) begin
                        r_rem <= PROD_W'(rem2 - {1'b0, r_s});
                        r_q   <= {r_q[WORD_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem2[PROD_W-1:0];
                        r_q   <= {r_q[WORD_W-2:0], 1'b0};
                    end
                end
                ST_GM: begin
                    r_prod <= gm_prod;
                end
                ST_WR: begin
                    r_ent[r_pair] <= ent_val;
                    if (r_pair != 3'd5) begin
                        r_pair <= r_pair + 3'd1;
                    end
                end
                default: begin
                    r_pair <= r_pair;
                end
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (wr_idx)
            REG_GAMMA: o_rd_data = r_gamma;
            REG_UX:    o_rd_data = r_ux;
            REG_UY:    o_rd_data = r_uy;
            default:   o_rd_data = r_uz;
        endcase
    end

    // Assemble the symmetric matrix
    always_comb begin
        o_matrix[0][0] = r_gamma;
        o_matrix[0][1] = neg_sat(r_ux);
        o_matrix[0][2] = neg_sat(r_uy);
        o_matrix[0][3] = neg_sat(r_uz);
        o_matrix[1][0] = neg_sat(r_ux);
        o_matrix[2][0] = neg_sat(r_uy);
        o_matrix[3][0] = neg_sat(r_uz);
        o_matrix[1][1] = r_ent[0];
        o_matrix[1][2] = r_ent[1];
        o_matrix[1][3] = r_ent[2];
        o_matrix[2][1] = r_ent[1];
        o_matrix[2][2] = r_ent[3];
        o_matrix[2][3] = r_ent[4];
        o_matrix[3][1] = r_ent[2];
        o_matrix[3][2] = r_ent[4];
        o_matrix[3][3] = r_ent[5];
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

/* rtl/lbt_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbt_lane
// One matrix row: four registered 32x32 products, then their exact sum.
// ----------------------------------------------------------------------------
module lbt_lane (
    input  logic                            i_clk,
    input  lbt_pkg::t_lane_ctl              i_ctl,
    input  lbt_pkg::t_row                   i_row,
    input  lbt_pkg::t_row                   i_vec,
    output logic signed [lbt_pkg::SUM_W-1:0] o_sum
);
    import lbt_pkg::*;

    logic signed [PROD_W-1:0] r_prod [4];
    logic signed [SUM_W-1:0]  r_sum;

    // Load the four products
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_prod) begin
            for (int c = 0; c < 4; c++) begin
                r_prod[c] <= $signed(i_row[c]) * $signed(i_vec[c]);
            end
        end
    end

    // Sum the row
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_sum) begin
            r_sum <= SUM_W'(r_prod[0]) + SUM_W'(r_prod[1])
                   + SUM_W'(r_prod[2]) + SUM_W'(r_prod[3]);
        end
    end

    assign o_sum = r_sum;

endmodule

/* rtl/lbt_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbt_merge
// Output stage: round each lane sum half up, saturate, and register the
// four components as one result word.
// ----------------------------------------------------------------------------
module lbt_merge #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_ld,
    input  lbt_pkg::t_sums i_sums,
    output lbt_pkg::t_row  o_res
);
    import lbt_pkg::*;

    localparam logic signed [WIDE_W-1:0] HALF_W = WIDE_W'(1) << (FRAC_BITS - 1);

    logic signed [WIDE_W-1:0] rnd [4];
    t_row r_res;

    // Round and clamp each component
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rnd[k] = (WIDE_W'($signed(i_sums[k])) + HALF_W) >>> FRAC_BITS;
        end
    end

    // Hold the result word
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            for (int k = 0; k < 4; k++) begin
                r_res[k] <= sat_word(rnd[k]);
            end
        end
    end

    assign o_res = r_res;

endmodule

/* rtl/lorentz_boost_transform.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorentz_boost_transform
// Lorentz boost of Q16.16 four-vectors by a matrix built from register
// configuration.
// ----------------------------------------------------------------------------
// Takes one four-vector word per cycle and returns one boosted word per
// cycle unless the result channel or a rebuild holds the flow; each word
// passes the product, sum and merge registers. Four row lanes of four
// multipliers each do the matrix-vector product; a merge stage rounds and
// saturates. After any register write a shared sequencer rebuilds the
// matrix with a one-bit-per-cycle divider and takes no input word meanwhile.
// No clearing pass runs after reset; the identity matrix is present at once.
module lorentz_boost_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lbt_vec_if.sink                    i_vec,
    lbt_res_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lbt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import lbt_pkg::*;

    logic      wr_en, busy, acc;
    logic      rdy1, rdy2, rdy3;
    logic      r_v1, r_v2, r_v3;
    t_word     rd_data;
    t_mat      matrix;
    t_row      vec, res;
    t_sums     sums;
    t_lane_ctl ctl;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = rd_data;

    lbt_builder #(.FRAC_BITS(FRAC_BITS)) u_builder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_addr    (paddr),
        .i_wr_data (pwdata),
        .o_rd_data (rd_data),
        .o_matrix  (matrix),
        .o_busy    (busy)
    );

    // Stage handshake: a stage moves when empty or when the next one moves
    assign rdy3        = !r_v3 || o_res.ready;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign i_vec.ready = rdy1 && !busy;
    assign acc         = i_vec.valid && i_vec.ready;
    assign ctl.ld_prod = acc;
    assign ctl.ld_sum  = r_v1 && rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= acc;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign vec = {i_vec.vec_z, i_vec.vec_y, i_vec.vec_x, i_vec.vec_t};

    // One lane per matrix row
    for (genvar k = 0; k < 4; k++) begin : g_lane
        lbt_lane u_lane (
            .i_clk (i_clk),
            .i_ctl (ctl),
            .i_row (matrix[k]),
            .i_vec (vec),
            .o_sum (sums[k])
        );
    end

    lbt_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .i_clk  (i_clk),
        .i_ld   (r_v2 && rdy3),
        .i_sums (sums),
        .o_res  (res)
    );

    assign o_res.valid = r_v3;
    assign o_res.out_t = res[0];
    assign o_res.out_x = res[1];
    assign o_res.out_y = res[2];
    assign o_res.out_z = res[3];

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the Lorentz boost transform.
// ----------------------------------------------------------------------------
// Programs boost four-velocities over the APB port, rebuilds its own copy of
// the boost matrix on each register write, and predicts each boosted
// four-vector. A monitor compares every result word in order, field by field.
// Both channels idle at random. One stretch holds the result channel off long
// enough to stall the input, and one stretch runs with no idling at all.
// ----------------------------------------------------------------------------
module tb_top;
    import lbt_pkg::*;

    localparam int FRAC     = 16;
    localparam int WD_LIMIT = 3000;
    localparam int HOLD_LEN = 300;

    typedef logic signed [95:0] t_wide;
    typedef struct packed {
        t_word t;
        t_word x;
        t_word y;
        t_word z;
    } t_vec4;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lbt_vec_if vin ();
    lbt_res_if vres ();

    lorentz_boost_transform #(.FRAC_BITS(FRAC)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (vin),
        .o_res   (vres),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: boost registers and the matrix built from them
    t_word boost_regs [4];
    t_word boost_mat [16];
    t_vec4 boosted_q [$];
    int    fail_cnt;
    logic  no_idle;
    int    hold_req_cnt;
    int    hold_seen_cnt;
    int    hold_left;
    int    quiet_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_word clamp_word(input t_wide v);
        if (v > t_wide'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
        if (v < -t_wide'(64'sh8000_0000)) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Rebuild the boost matrix from the current registers
    function automatic void rebuild_boost();
        t_wide u [3];
        t_wide s, gm1, p, m, q, rem, r, term;
        u[0] = boost_regs[REG_UX];
        u[1] = boost_regs[REG_UY];
        u[2] = boost_regs[REG_UZ];
        s = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        gm1 = t_wide'(boost_regs[REG_GAMMA]) - (t_wide'(1) <<< FRAC);
        boost_mat[0] = boost_regs[REG_GAMMA];
        for (int i = 0; i < 3; i++) begin
            boost_mat[i + 1] = clamp_word(-u[i]);
            boost_mat[(i + 1) * 4] = clamp_word(-u[i]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p = u[i] * u[j];
                m = (p < 0) ? -p : p;
                if (s == 0) begin
                    r = 0;
                end else begin
                    q = (m <<< FRAC) / s;
                    rem = (m <<< FRAC) % s;
                    if (rem != 0 && 2 * rem >= s) q = q + 1;
                    r = (p < 0) ? -q : q;
                end
                term = (gm1 * r + (t_wide'(1) <<< (FRAC - 1))) >>> FRAC;
                if (i == j) term = term + (t_wide'(1) <<< FRAC);
                boost_mat[(i + 1) * 4 + j + 1] = clamp_word(term);
            end
        end
    endfunction

    // Matrix times vector, rounded half up and clamped
    function automatic t_vec4 boost_vector(input t_vec4 v);
        t_word vc [4];
        t_word oc [4];
        t_wide acc;
        t_vec4 res;
        vc[0] = v.t; vc[1] = v.x; vc[2] = v.y; vc[3] = v.z;
        for (int rw = 0; rw < 4; rw++) begin
            acc = 0;
            for (int c = 0; c < 4; c++) begin
                acc = acc + t_wide'(boost_mat[rw * 4 + c]) * t_wide'(vc[c]);
            end
            oc[rw] = clamp_word((acc + (t_wide'(1) <<< (FRAC - 1))) >>> FRAC);
        end
        res.t = oc[0]; res.x = oc[1]; res.y = oc[2]; res.z = oc[3];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_cnt++;
    endtask

    // Result monitor: compare each word with the oldest prediction
    always @(posedge i_clk) begin
        t_vec4 want;
        if (i_rst_n && vres.valid && vres.ready) begin
            if (boosted_q.size() == 0) begin
                report_mismatch("unexpected word", vres.out_t, 'x);
            end else begin
                want = boosted_q.pop_front();
                if (vres.out_t !== want.t) report_mismatch("out_t", vres.out_t, want.t);
                if (vres.out_x !== want.x) report_mismatch("out_x", vres.out_x, want.x);
                if (vres.out_y !== want.y) report_mismatch("out_y", vres.out_y, want.y);
                if (vres.out_z !== want.z) report_mismatch("out_z", vres.out_z, want.z);
            end
        end
    end

    // Result ready: random idling, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vres.ready <= 1'b0;
            hold_left <= 0;
            hold_seen_cnt <= 0;
        end else if (hold_seen_cnt != hold_req_cnt) begin
            hold_seen_cnt <= hold_req_cnt;
            hold_left <= HOLD_LEN;
            vres.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            vres.ready <= 1'b0;
        end else begin
            vres.ready <= no_idle || ($urandom_range(99) >= 15);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (vin.valid && vin.ready) || (vres.valid && vres.ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WD_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one four-vector word and record its prediction on acceptance
    task automatic send_vec(input t_word t, input t_word x, input t_word y, input t_word z);
        t_vec4 v;
        v = {t, x, y, z};
        while (!no_idle && $urandom_range(99) < 15) begin
            vin.valid <= 1'b0;
            @(posedge i_clk);
        end
        vin.valid <= 1'b1;
        vin.vec_t <= t;
        vin.vec_x <= x;
        vin.vec_y <= y;
        vin.vec_z <= z;
        @(posedge i_clk);
        while (!vin.ready) @(posedge i_clk);
        boosted_q.push_back(boost_vector(v));
    endtask

    task automatic drain();
        vin.valid <= 1'b0;
        @(posedge i_clk);
        while (boosted_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write one register, read it back, wait for the rebuild to finish
    task automatic write_reg(input t_reg_idx idx, input t_word val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        boost_regs[idx] = val;
        rebuild_boost();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== val) report_mismatch("prdata", prdata, val);
        psel <= 1'b0;
        penable <= 1'b0;
        repeat (3) @(posedge i_clk);
        while (!vin.ready) @(posedge i_clk);
    endtask

    task automatic set_boost(input t_word g, input t_word ux, input t_word uy, input t_word uz);
        drain();
        write_reg(REG_GAMMA, g);
        write_reg(REG_UX, ux);
        write_reg(REG_UY, uy);
        write_reg(REG_UZ, uz);
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(2097152)) - 1048576;
            2: return $signed($urandom_range(655360)) - 327680;
            default: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        endcase
    endfunction

    task automatic send_extremes();
        send_vec(32'sh0001_0000, 0, 0, 0);
        send_vec(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_vec(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001, -1);
        send_vec(32'sh0000_8000, -32'sh0000_8000, 32'sh0001_8000, 0);
    endtask

    // Identity matrix straight out of reset
    task automatic test_reset_identity();
        send_extremes();
        send_vec(32'sh1234_5678, 32'shfedc_ba98, 0, 32'sh0000_7fff);
    endtask

    // Special boosts: zero spatial part, extreme registers, rounding ties
    task automatic test_special_boosts();
        set_boost(32'sh0003_0000, 0, 0, 0);
        send_extremes();
        set_boost(32'sh0001_4000, 32'sh0000_c000, 0, 0);
        send_extremes();
        set_boost(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_extremes();
        set_boost(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1);
        send_extremes();
        set_boost(32'sh0002_0000, 1, 1, 1);
        send_vec(32'sh0000_0003, 32'sh0000_0005, -32'sh0000_0007, 32'sh0001_0001);
    endtask

    // Random boosts and vectors, with a hold-off and a no-idle stretch
    task automatic test_random_stream();
        for (int ph = 0; ph < 12; ph++) begin
            set_boost(rand_word(), rand_word(), rand_word(), rand_word());
            no_idle = (ph == 5);
            for (int n = 0; n < 150; n++) begin
                if (ph == 3 && n == 20) hold_req_cnt++;
                send_vec(rand_word(), rand_word(), rand_word(), rand_word());
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        vin.valid = 1'b0;
        vin.vec_t = '0;
        vin.vec_x = '0;
        vin.vec_y = '0;
        vin.vec_z = '0;
        fail_cnt = 0;
        no_idle = 1'b0;
        hold_req_cnt = 0;
        boost_regs[REG_GAMMA] = 32'sh0001_0000;
        boost_regs[REG_UX] = 0;
        boost_regs[REG_UY] = 0;
        boost_regs[REG_UZ] = 0;
        rebuild_boost();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_identity();
        test_special_boosts();
        test_random_stream();
        drain();
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
